/* src/mpp_pkg.sv */
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared constants and types of the median edge detector pixel predictor.
// ----------------------------------------------------------------------------
package mpp_pkg;

  // Line store depth: longest row that the block handles.
  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  // Compare width for row length: holds MAX_WIDTH and the 13-bit register.
  localparam int WCMP_W    = (ADDR_W + 1 > 13) ? ADDR_W + 1 : 13;

  localparam int SAMPLE_W  = 8;
  localparam int RESID_W   = 9;
  localparam int CFG_WID_W = 13;
  localparam int CFG_HGT_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 16'd480;

  // Position of the sample being taken in, from the counters.
  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic              first_row;
    logic              first_col;
    logic              last;
  } pos_t;

endpackage

/* src/mpp_ctrl.sv */
// ----------------------------------------------------------------------------
// mpp_ctrl
// Configuration registers and raster position counters.
// ----------------------------------------------------------------------------
module mpp_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpp_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                             accept,
  output mpp_pkg::pos_t                    pos
);

  localparam int AW = mpp_pkg::ADDR_W;
  localparam int CW = mpp_pkg::WCMP_W;

  logic [mpp_pkg::CFG_WID_W-1:0] width_r;
  logic [mpp_pkg::CFG_HGT_W-1:0] height_r;
  logic [AW-1:0]                 col_r, col_nxt;
  logic [mpp_pkg::CFG_HGT_W-1:0] row_r, row_nxt;

  logic [CW-1:0] w_raw, w_eff, col_ext, col_cur;
  logic [mpp_pkg::CFG_HGT_W:0] h_eff, row_inc;
  logic          row_end, img_end;

  always_comb begin
    w_raw = CW'(width_r);
    if (w_raw == '0) begin
      w_eff = CW'(1);
    end else if (w_raw > CW'(mpp_pkg::MAX_WIDTH)) begin
      w_eff = CW'(mpp_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    col_ext = CW'(col_r);
    col_cur = (col_ext >= w_eff) ? w_eff - CW'(1) : col_ext;
    row_end = (col_cur + CW'(1)) >= w_eff;
    h_eff   = (height_r == '0) ? (mpp_pkg::CFG_HGT_W+1)'(1) : {1'b0, height_r};
    row_inc = {1'b0, row_r} + (mpp_pkg::CFG_HGT_W+1)'(1);
    img_end = row_end && (row_inc >= h_eff);

    pos.col       = col_cur[AW-1:0];
    pos.first_row = (row_r == '0);
    pos.first_col = (col_cur == '0);
    pos.last      = img_end;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = img_end ? '0 : row_inc[mpp_pkg::CFG_HGT_W-1:0];
      end else begin
        col_nxt = col_cur[AW-1:0] + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mpp_pkg::WIDTH_RESET;
      height_r <= mpp_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      // any register write restarts the image
      case (cfg_index)
        mpp_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[mpp_pkg::CFG_WID_W-1:0];
        mpp_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata[mpp_pkg::CFG_HGT_W-1:0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* src/mpp_line_store.sv */
// ----------------------------------------------------------------------------
// mpp_line_store
// Previous-row sample memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module mpp_line_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [mpp_pkg::ADDR_W-1:0]     rd_addr,
  output logic [mpp_pkg::SAMPLE_W-1:0]   rd_data,
  input  logic                           wr_en,
  input  logic [mpp_pkg::ADDR_W-1:0]     wr_addr,
  input  logic [mpp_pkg::SAMPLE_W-1:0]   wr_data
);

  logic [mpp_pkg::SAMPLE_W-1:0] mem [mpp_pkg::MAX_WIDTH];
  logic [mpp_pkg::SAMPLE_W-1:0] q_r;
  logic [mpp_pkg::SAMPLE_W-1:0] fwd_data_r;
  logic                         fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // read and write of the same entry at one edge: take the new sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

/* src/mpp_med_stage.sv */
// ----------------------------------------------------------------------------
// mpp_med_stage
// Neighbor selection, median edge detector, residual and output register.
// ----------------------------------------------------------------------------
module mpp_med_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  mpp_pkg::pos_t                   pos,
  input  logic [mpp_pkg::SAMPLE_W-1:0]    sample,
  output logic                            s1_free,
  input  logic [mpp_pkg::SAMPLE_W-1:0]    above,
  output logic                            wr_en,
  output logic [mpp_pkg::ADDR_W-1:0]      wr_addr,
  output logic [mpp_pkg::SAMPLE_W-1:0]    wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpp_pkg::SAMPLE_W-1:0]    out_pred,
  output logic [mpp_pkg::RESID_W-1:0]     out_resid,
  output logic                            out_last
);

  localparam int SW = mpp_pkg::SAMPLE_W;

  logic          s1_valid_r;
  mpp_pkg::pos_t s1_pos_r;
  logic [SW-1:0] s1_x_r;
  logic [SW-1:0] left_r, above_left_r, row_start_above_r;
  logic          out_valid_r;
  logic [SW-1:0] pred_r;
  logic [mpp_pkg::RESID_W-1:0] resid_r;
  logic          last_r;

  logic          adv;
  logic [SW-1:0] a, b, c, lo, hi, pred;
  logic [SW+1:0] grad;
  logic [mpp_pkg::RESID_W-1:0] resid;

  assign adv     = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_free = !s1_valid_r || adv;

  always_comb begin
    b    = s1_pos_r.first_row ? '0 : above;
    c    = s1_pos_r.first_row ? '0 :
           (s1_pos_r.first_col ? row_start_above_r : above_left_r);
    a    = s1_pos_r.first_col ? b : left_r;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    grad = {2'b00, a} + {2'b00, b} - {2'b00, c};
    if (c >= hi) begin
      pred = lo;
    end else if (c <= lo) begin
      pred = hi;
    end else begin
      pred = grad[SW-1:0];
    end
    resid = {1'b0, s1_x_r} - {1'b0, pred};
  end

  assign wr_en   = adv;
  assign wr_addr = s1_pos_r.col;
  assign wr_data = s1_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      left_r            <= '0;
      above_left_r      <= '0;
      row_start_above_r <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r  <= 1'b1;
        left_r       <= s1_x_r;
        above_left_r <= b;
        if (s1_pos_r.first_col) begin
          row_start_above_r <= b;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r <= pos;
      s1_x_r   <= sample;
    end
    if (adv) begin
      pred_r  <= pred;
      resid_r <= resid;
      last_r  <= s1_pos_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pred  = pred_r;
  assign out_resid = resid_r;
  assign out_last  = last_r;

endmodule

/* src/med_pixel_predictor.sv */
// ----------------------------------------------------------------------------
// med_pixel_predictor
// JPEG-LS median edge detector predictor over a raster stream of 8-bit
// samples, with a line store for the previous row.
// ----------------------------------------------------------------------------
//   channel | dir | request fields
//   in_     | in  | tdata[7:0] sample
//   out_    | out | tdata[7:0] prediction, tdata[16:8] residual; tlast end_of_image
//   cfg_    | in  | index 0 image_width, 1 image_height; no read-back
//
// One sample per cycle sustained while the output does not stall; the line
// store read is registered with the sample, the predictor result in the
// output register. The line store is written back as a sample leaves the
// predictor stage; a read of the same entry at that edge is forwarded.
// Synchronous active-low reset; the line store holds no reset. A register
// write restarts the image. Output stalls back up into in_tready.
// ----------------------------------------------------------------------------
module med_pixel_predictor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mpp_pkg::IN_TDATA_W-1:0]       in_tdata,   // [7:0] sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mpp_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [7:0] prediction, [16:8] residual
  output logic                                 out_tlast,  // end_of_image
  input  logic                                 cfg_we,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpp_pkg::CFG_DAT_W-1:0]        cfg_wdata
);

  logic                          accept;
  logic                          s1_free;
  mpp_pkg::pos_t                 pos;
  logic [mpp_pkg::SAMPLE_W-1:0]  above;
  logic                          wr_en;
  logic [mpp_pkg::ADDR_W-1:0]    wr_addr;
  logic [mpp_pkg::SAMPLE_W-1:0]  wr_data;
  logic [mpp_pkg::SAMPLE_W-1:0]  pred;
  logic [mpp_pkg::RESID_W-1:0]   resid;

  assign in_tready = s1_free;
  assign accept    = in_tvalid && s1_free;

  mpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pos       (pos)
  );

  mpp_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (pos.col),
    .rd_data (above),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mpp_med_stage u_med (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pos       (pos),
    .sample    (in_tdata[mpp_pkg::SAMPLE_W-1:0]),
    .s1_free   (s1_free),
    .above     (above),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pred  (pred),
    .out_resid (resid),
    .out_last  (out_tlast)
  );

  assign out_tdata = {(mpp_pkg::OUT_TDATA_W - mpp_pkg::SAMPLE_W - mpp_pkg::RESID_W)'(0),
                      resid, pred};

endmodule
